@@ rtl/rsps_pkg.sv @@
// Shared types and constants of the ray-sphere pixel shader
package rsps_pkg;

  localparam int COORD_BITS_DEF = 16;

  localparam int PIX_W      = 12;
  localparam int LEN_W      = 15;
  localparam int LIGHT_W    = 9;
  localparam int COLOR_W    = 24;
  localparam int CH_W       = 8;
  localparam int DIST_W     = 16;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_CENTER_X        = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y        = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Z        = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPHERE_RADIUS   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_DISTANCE = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT_LEVEL     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SPHERE_COLOR    = 3'd6;

  localparam int                 CENTER_X_RST = 0;
  localparam int                 CENTER_Y_RST = 0;
  localparam int                 CENTER_Z_RST = -1500;
  localparam logic [LEN_W-1:0]   RADIUS_RST   = 15'd150;
  localparam logic [LEN_W-1:0]   SCREEN_RST   = 15'd1000;
  localparam logic [LIGHT_W-1:0] LIGHT_RST    = 9'd135;
  localparam logic [COLOR_W-1:0] COLOR_RST    = 24'h33E6E6;

  typedef struct packed {
    logic [LEN_W-1:0]   radius;
    logic [LEN_W-1:0]   screen_dist;
    logic [LIGHT_W-1:0] light;
    logic [COLOR_W-1:0] color;
  } cfg_t;

endpackage

@@ rtl/rsps_in_if.sv @@
// Pixel input channel
interface rsps_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [rsps_pkg::PIX_W-1:0] pixel_x;
  logic signed [rsps_pkg::PIX_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

@@ rtl/rsps_out_if.sv @@
// Shaded pixel result channel
interface rsps_out_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [rsps_pkg::DIST_W-1:0] distance;
  logic [rsps_pkg::CH_W-1:0]   red;
  logic [rsps_pkg::CH_W-1:0]   green;
  logic [rsps_pkg::CH_W-1:0]   blue;

  modport source (output valid, output hit, output distance, output red, output green,
                  output blue, input ready);
  modport sink   (input valid, input hit, input distance, input red, input green,
                  input blue, output ready);
endinterface

@@ rtl/rsps_datapath.sv @@
// Pipelined ray normalize, sphere intersect and shade datapath
module rsps_datapath #(
  parameter int COORD_BITS = rsps_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [rsps_pkg::PIX_W-1:0]    pixel_x,
  input  logic signed [rsps_pkg::PIX_W-1:0]    pixel_y,
  input  logic signed [COORD_BITS-1:0]         center_x,
  input  logic signed [COORD_BITS-1:0]         center_y,
  input  logic signed [COORD_BITS-1:0]         center_z,
  input  rsps_pkg::cfg_t                       cfg,
  output logic                                 out_valid,
  output logic                                 hit,
  output logic [rsps_pkg::DIST_W-1:0]          distance,
  output logic [rsps_pkg::CH_W-1:0]            red,
  output logic [rsps_pkg::CH_W-1:0]            green,
  output logic [rsps_pkg::CH_W-1:0]            blue
);

  localparam int CB       = COORD_BITS;
  localparam int SQ1_N    = 31;
  localparam int SQ2_N    = 30;
  localparam int DV_N     = 16;
  localparam int REM_W    = 34;
  localparam int ROOT_W   = 32;
  localparam int PR_W     = CB + 16;
  localparam int B_W      = CB + 18;
  localparam int BV_W     = B_W + 16;
  localparam int P_W      = B_W + 2;
  localparam int AP_CMP_W = (P_W > 30) ? P_W : 30;
  localparam int T_W      = ((B_W > 31) ? B_W : 31) + 1;

  function automatic logic [REM_W+ROOT_W-1:0] sq_step(input logic [REM_W-1:0]  rem,
                                                      input logic [ROOT_W-1:0] root,
                                                      input logic [1:0]        pair);
    logic [REM_W-1:0] rs;
    logic [REM_W-1:0] tr;
    rs = {rem[REM_W-3:0], pair};
    tr = {root, 2'b01};
    if (rs >= tr) begin
      sq_step = {rs - tr, root[ROOT_W-2:0], 1'b1};
    end else begin
      sq_step = {rs, root[ROOT_W-2:0], 1'b0};
    end
  endfunction

  function automatic logic [rsps_pkg::CH_W-1:0] shade(input logic [rsps_pkg::LIGHT_W-1:0] lv,
                                                      input logic [rsps_pkg::CH_W-1:0] ch);
    logic [16:0] pr;
    pr = lv * ch;
    shade = pr[16] ? 8'hFF : pr[15:8];
  endfunction

  logic signed [CB-1:0] c [3];
  assign c[0] = center_x;
  assign c[1] = center_y;
  assign c[2] = center_z;

  // ---------------- length squared and first square root ----------------
  logic signed [23:0] xx;
  logic signed [23:0] yy;
  logic [29:0]        dd;
  logic [30:0]        l2_in;

  always_comb begin
    xx    = pixel_x * pixel_x;
    yy    = pixel_y * pixel_y;
    dd    = cfg.screen_dist * cfg.screen_dist;
    l2_in = 31'(xx[22:0]) + 31'(yy[22:0]) + 31'(dd);
  end

  logic [SQ1_N:0]              s1_v_r;
  logic [SQ1_N:0][11:0]        s1_wx_r;
  logic [SQ1_N:0][11:0]        s1_wy_r;
  logic [SQ1_N:0][30:0]        s1_l2_r;
  logic [SQ1_N:0][REM_W-1:0]   s1_rem_r;
  logic [SQ1_N:0][ROOT_W-1:0]  s1_root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r[0] <= 1'b0;
    end else if (en) begin
      s1_v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_wx_r[0]   <= pixel_x;
      s1_wy_r[0]   <= pixel_y;
      s1_l2_r[0]   <= l2_in;
      s1_rem_r[0]  <= '0;
      s1_root_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < SQ1_N; j++) begin : g_sq1
    logic [61:0]               n;
    logic [REM_W+ROOT_W-1:0]   st;
    assign n  = {1'b0, s1_l2_r[j], 30'b0};
    assign st = sq_step(s1_rem_r[j], s1_root_r[j], n[61-2*j -: 2]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s1_v_r[j+1] <= 1'b0;
      end else if (en) begin
        s1_v_r[j+1] <= s1_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s1_wx_r[j+1]   <= s1_wx_r[j];
        s1_wy_r[j+1]   <= s1_wy_r[j];
        s1_l2_r[j+1]   <= s1_l2_r[j];
        s1_rem_r[j+1]  <= st[REM_W+ROOT_W-1:ROOT_W];
        s1_root_r[j+1] <= st[ROOT_W-1:0];
      end
    end
  end

  // ---------------- direction divide, three lanes ----------------
  logic [DV_N:0]             dv_v_r;
  logic [DV_N:0]             dv_zero_r;
  logic [DV_N:0][1:0]        dv_neg_r;
  logic [DV_N:0][30:0]       dv_s_r;
  logic [DV_N:0][2:0][31:0]  dv_rem_r;
  logic [DV_N:0][2:0][15:0]  dv_q_r;

  logic [11:0] wx_last;
  logic [11:0] wy_last;
  logic [11:0] magx;
  logic [11:0] magy;

  always_comb begin
    wx_last = s1_wx_r[SQ1_N];
    wy_last = s1_wy_r[SQ1_N];
    magx    = wx_last[11] ? (~wx_last + 12'd1) : wx_last;
    magy    = wy_last[11] ? (~wy_last + 12'd1) : wy_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= s1_v_r[SQ1_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_zero_r[0]   <= (s1_l2_r[SQ1_N] == '0);
      dv_neg_r[0]    <= {wy_last[11], wx_last[11]};
      dv_s_r[0]      <= s1_root_r[SQ1_N][30:0];
      dv_rem_r[0][0] <= {3'b0, 3'b0, magx, 14'b0};
      dv_rem_r[0][1] <= {3'b0, 3'b0, magy, 14'b0};
      dv_rem_r[0][2] <= {3'b0, cfg.screen_dist, 14'b0};
      dv_q_r[0]      <= '0;
    end
  end

  for (genvar j = 0; j < DV_N; j++) begin : g_div
    logic [2:0][31:0] rem_nxt;
    logic [2:0][15:0] q_nxt;

    always_comb begin
      logic [31:0] rs;
      for (int i = 0; i < 3; i++) begin
        rs = {dv_rem_r[j][i][30:0], 1'b0};
        if (rs >= {1'b0, dv_s_r[j]}) begin
          rem_nxt[i] = rs - {1'b0, dv_s_r[j]};
          q_nxt[i]   = {dv_q_r[j][i][14:0], 1'b1};
        end else begin
          rem_nxt[i] = rs;
          q_nxt[i]   = {dv_q_r[j][i][14:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_zero_r[j+1] <= dv_zero_r[j];
        dv_neg_r[j+1]  <= dv_neg_r[j];
        dv_s_r[j+1]    <= dv_s_r[j];
        dv_rem_r[j+1]  <= rem_nxt;
        dv_q_r[j+1]    <= q_nxt;
      end
    end
  end

  // ---------------- unit vector, dot product, offsets ----------------
  logic                 vv_v_r, pr_v_r, b_v_r, bv_v_r, pp_v_r, pa_v_r, sq_v_r;
  logic                 vv_zero_r, pr_zero_r, b_zero_r, bv_zero_r, pp_zero_r;
  logic                 pa_miss_r, sq_miss_r;
  logic [2:0][15:0]     vv_r, pr_vv_r, b_vv_r;
  logic signed [PR_W-1:0] pr_r [3];
  logic signed [B_W-1:0]  b_r, bv_b_r, pp_b_r, pa_b_r, sq_b_r;
  logic signed [BV_W-1:0] bv_r [3];
  logic signed [P_W-1:0]  p_r [3];
  logic [2:0][29:0]     ap_r;
  logic [2:0][59:0]     sq_r;
  logic [59:0]          r2_r;

  logic [2:0][15:0]     vv_nxt;
  logic [2:0]           neg_all;

  always_comb begin
    logic [15:0] qs;
    neg_all = {1'b1, dv_neg_r[DV_N]};
    for (int i = 0; i < 3; i++) begin
      qs        = dv_q_r[DV_N][i][15] ? 16'd32767 : dv_q_r[DV_N][i];
      vv_nxt[i] = neg_all[i] ? (16'd0 - qs) : qs;
    end
  end

  logic signed [P_W-1:0]  p_nxt [3];
  logic [2:0][29:0]       ap_nxt;
  logic                   far_any;
  logic [29:0]            rq;

  assign rq = {cfg.radius, 15'b0};

  always_comb begin
    logic signed [BV_W-1:0] adj;
    for (int i = 0; i < 3; i++) begin
      adj      = bv_r[i] + $signed({{(BV_W-15){1'b0}}, {15{bv_r[i][BV_W-1]}}});
      p_nxt[i] = (P_W'(c[i]) <<< 15) - P_W'(adj >>> 15);
    end
  end

  always_comb begin
    logic [P_W-1:0]      ap;
    logic [AP_CMP_W-1:0] apw;
    far_any = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ap        = p_r[i][P_W-1] ? (~p_r[i] + 1'b1) : p_r[i];
      apw       = AP_CMP_W'(ap);
      far_any   = far_any | (apw > AP_CMP_W'(rq));
      ap_nxt[i] = apw[29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vv_v_r <= 1'b0;
      pr_v_r <= 1'b0;
      b_v_r  <= 1'b0;
      bv_v_r <= 1'b0;
      pp_v_r <= 1'b0;
      pa_v_r <= 1'b0;
      sq_v_r <= 1'b0;
    end else if (en) begin
      vv_v_r <= dv_v_r[DV_N];
      pr_v_r <= vv_v_r;
      b_v_r  <= pr_v_r;
      bv_v_r <= b_v_r;
      pp_v_r <= bv_v_r;
      pa_v_r <= pp_v_r;
      sq_v_r <= pa_v_r;
    end
  end

  always_ff @(posedge clk) begin
    r2_r <= rq * rq;
    if (en) begin
      vv_r      <= vv_nxt;
      vv_zero_r <= dv_zero_r[DV_N];
      for (int i = 0; i < 3; i++) begin
        pr_r[i] <= $signed(vv_r[i]) * c[i];
      end
      pr_vv_r   <= vv_r;
      pr_zero_r <= vv_zero_r;
      b_r       <= B_W'(pr_r[0]) + B_W'(pr_r[1]) + B_W'(pr_r[2]);
      b_vv_r    <= pr_vv_r;
      b_zero_r  <= pr_zero_r;
      for (int i = 0; i < 3; i++) begin
        bv_r[i] <= b_r * $signed(b_vv_r[i]);
      end
      bv_b_r    <= b_r;
      bv_zero_r <= b_zero_r;
      for (int i = 0; i < 3; i++) begin
        p_r[i] <= p_nxt[i];
      end
      pp_b_r    <= bv_b_r;
      pp_zero_r <= bv_zero_r;
      ap_r      <= ap_nxt;
      pa_b_r    <= pp_b_r;
      pa_miss_r <= pp_zero_r | far_any;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= ap_r[i] * ap_r[i];
      end
      sq_b_r    <= pa_b_r;
      sq_miss_r <= pa_miss_r;
    end
  end

  // ---------------- discriminant and second square root ----------------
  logic [61:0] h2;
  logic [59:0] dsc;
  logic        over;

  always_comb begin
    h2   = 62'(sq_r[0]) + 62'(sq_r[1]) + 62'(sq_r[2]);
    over = h2 > 62'(r2_r);
    dsc  = 60'(62'(r2_r) - h2);
  end

  logic [SQ2_N:0]             s2_v_r;
  logic [SQ2_N:0]             s2_miss_r;
  logic [SQ2_N:0][B_W-1:0]    s2_b_r;
  logic [SQ2_N:0][59:0]       s2_d_r;
  logic [SQ2_N:0][REM_W-1:0]  s2_rem_r;
  logic [SQ2_N:0][ROOT_W-1:0] s2_root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r[0] <= 1'b0;
    end else if (en) begin
      s2_v_r[0] <= sq_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_miss_r[0] <= sq_miss_r | over;
      s2_b_r[0]    <= sq_b_r;
      s2_d_r[0]    <= dsc;
      s2_rem_r[0]  <= '0;
      s2_root_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < SQ2_N; j++) begin : g_sq2
    logic [REM_W+ROOT_W-1:0] st;
    assign st = sq_step(s2_rem_r[j], s2_root_r[j], s2_d_r[j][59-2*j -: 2]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s2_v_r[j+1] <= 1'b0;
      end else if (en) begin
        s2_v_r[j+1] <= s2_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s2_miss_r[j+1] <= s2_miss_r[j];
        s2_b_r[j+1]    <= s2_b_r[j];
        s2_d_r[j+1]    <= s2_d_r[j];
        s2_rem_r[j+1]  <= st[REM_W+ROOT_W-1:ROOT_W];
        s2_root_r[j+1] <= st[ROOT_W-1:0];
      end
    end
  end

  // ---------------- nearer root, distance, color ----------------
  logic signed [T_W-1:0]  t;
  logic [T_W-17:0]        hi;
  logic                   hit_nxt;
  logic [15:0]            dist_nxt;

  always_comb begin
    t        = T_W'($signed(s2_b_r[SQ2_N])) - T_W'($signed({1'b0, s2_root_r[SQ2_N][29:0]}));
    hi       = t[T_W-2:15];
    hit_nxt  = !s2_miss_r[SQ2_N] && !t[T_W-1] && (t != '0);
    dist_nxt = (|(hi >> 16)) ? 16'hFFFF : hi[15:0];
  end

  logic        out_valid_r;
  logic        hit_r;
  logic [15:0] distance_r;
  logic [7:0]  red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s2_v_r[SQ2_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r      <= hit_nxt;
      distance_r <= hit_nxt ? dist_nxt : '0;
      red_r      <= hit_nxt ? shade(cfg.light, cfg.color[23:16]) : '0;
      green_r    <= hit_nxt ? shade(cfg.light, cfg.color[15:8]) : '0;
      blue_r     <= hit_nxt ? shade(cfg.light, cfg.color[7:0]) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign hit       = hit_r;
  assign distance  = distance_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;

endmodule

@@ rtl/ray_sphere_pixel_shader.sv @@
// Top level of the ray-sphere pixel shader: register file and pipeline
//
// Pixels (pixel_x, pixel_y) enter on in_pix; one shaded result per pixel
// leaves on out_px in the same order: hit, distance and red/green/blue.
// The sphere, eye distance, light level and color sit in an APB register
// file (byte address 4*index, pready tied high); write it only while idle.
// Two bit-per-stage square root pipelines (31 and 30 stages) and a
// 16-stage restoring divider make up most of the pipeline. Throughput
// is one pixel per cycle while out_px takes every result.
// When out_px stalls the whole pipeline holds and in_pix.ready drops
// until the waiting result is taken.
// Reset (rst_n low at a clock edge) empties the pipeline and loads the
// default scene registers.
module ray_sphere_pixel_shader #(
  parameter int COORD_BITS = rsps_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  rsps_in_if.sink                             in_pix,
  rsps_out_if.source                          out_px,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rsps_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [rsps_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [rsps_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  logic [COORD_BITS-1:0]            center_x_r;
  logic [COORD_BITS-1:0]            center_y_r;
  logic [COORD_BITS-1:0]            center_z_r;
  logic [rsps_pkg::LEN_W-1:0]       radius_r;
  logic [rsps_pkg::LEN_W-1:0]       screen_r;
  logic [rsps_pkg::LIGHT_W-1:0]     light_r;
  logic [rsps_pkg::COLOR_W-1:0]     color_r;

  logic                             wr_en;
  logic [rsps_pkg::REG_IDX_W-1:0]   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[rsps_pkg::APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= COORD_BITS'(rsps_pkg::CENTER_X_RST);
      center_y_r <= COORD_BITS'(rsps_pkg::CENTER_Y_RST);
      center_z_r <= COORD_BITS'(rsps_pkg::CENTER_Z_RST);
      radius_r   <= rsps_pkg::RADIUS_RST;
      screen_r   <= rsps_pkg::SCREEN_RST;
      light_r    <= rsps_pkg::LIGHT_RST;
      color_r    <= rsps_pkg::COLOR_RST;
    end else if (wr_en) begin
      case (reg_idx)
        rsps_pkg::REG_CENTER_X:        center_x_r <= pwdata[COORD_BITS-1:0];
        rsps_pkg::REG_CENTER_Y:        center_y_r <= pwdata[COORD_BITS-1:0];
        rsps_pkg::REG_CENTER_Z:        center_z_r <= pwdata[COORD_BITS-1:0];
        rsps_pkg::REG_SPHERE_RADIUS:   radius_r   <= pwdata[rsps_pkg::LEN_W-1:0];
        rsps_pkg::REG_SCREEN_DISTANCE: screen_r   <= pwdata[rsps_pkg::LEN_W-1:0];
        rsps_pkg::REG_LIGHT_LEVEL:     light_r    <= pwdata[rsps_pkg::LIGHT_W-1:0];
        rsps_pkg::REG_SPHERE_COLOR:    color_r    <= pwdata[rsps_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rsps_pkg::REG_CENTER_X:        prdata = 32'(center_x_r);
      rsps_pkg::REG_CENTER_Y:        prdata = 32'(center_y_r);
      rsps_pkg::REG_CENTER_Z:        prdata = 32'(center_z_r);
      rsps_pkg::REG_SPHERE_RADIUS:   prdata = 32'(radius_r);
      rsps_pkg::REG_SCREEN_DISTANCE: prdata = 32'(screen_r);
      rsps_pkg::REG_LIGHT_LEVEL:     prdata = 32'(light_r);
      rsps_pkg::REG_SPHERE_COLOR:    prdata = 32'(color_r);
      default:                       prdata = '0;
    endcase
  end

  rsps_pkg::cfg_t cfg;
  logic           en;

  assign cfg.radius      = radius_r;
  assign cfg.screen_dist = screen_r;
  assign cfg.light       = light_r;
  assign cfg.color       = color_r;

  // advance whenever the output register is empty or being taken
  assign en           = !out_px.valid || out_px.ready;
  assign in_pix.ready = en;

  rsps_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_pix.valid),
    .pixel_x   (in_pix.pixel_x),
    .pixel_y   (in_pix.pixel_y),
    .center_x  ($signed(center_x_r)),
    .center_y  ($signed(center_y_r)),
    .center_z  ($signed(center_z_r)),
    .cfg       (cfg),
    .out_valid (out_px.valid),
    .hit       (out_px.hit),
    .distance  (out_px.distance),
    .red       (out_px.red),
    .green     (out_px.green),
    .blue      (out_px.blue)
  );

endmodule

@@ verif/ray_sphere_pixel_shader_tb.sv @@
// Self-checking testbench of the ray-sphere pixel shader: directed table, random bursts, APB scenes
module ray_sphere_pixel_shader_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 88;

  typedef struct packed {
    logic        hit;
    logic [15:0] distance;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } shade_t;

  typedef struct {
    logic signed [11:0] x;
    logic signed [11:0] y;
    bit                 known;
    shade_t             res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [rsps_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [rsps_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [rsps_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  rsps_in_if  in_pix();
  rsps_out_if out_px();

  ray_sphere_pixel_shader dut (
    .clk(clk), .rst_n(rst_n), .in_pix(in_pix), .out_px(out_px),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  logic signed [15:0] cx, cy, cz;
  logic [14:0] radius, scr_dist;
  logic [8:0]  light;
  logic [23:0] color;

  shade_t expected_px[$];
  int     errors = 0;
  bit     rx_stall_en = 1'b1;

  initial begin
    in_pix.valid = 1'b0;
    in_pix.pixel_x = '0;
    in_pix.pixel_y = '0;
    out_px.ready = 1'b0;
  end

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [7:0] lit(logic [7:0] ch);
    longint unsigned s;
    s = (longint'(light) * ch) >> 8;
    return s > 255 ? 8'd255 : s[7:0];
  endfunction

  function automatic shade_t shade_pixel(logic signed [11:0] px, logic signed [11:0] py);
    longint w[3], c[3], v[3];
    longint unsigned l2, s, q, rq, h2, ap, dq, ub;
    longint b, t, p;
    shade_t o;
    o = '{1'b0, 16'd0, 8'd0, 8'd0, 8'd0};
    w[0] = px; w[1] = py; w[2] = -longint'(scr_dist);
    c[0] = cx; c[1] = cy; c[2] = cz;
    l2 = w[0]*w[0] + w[1]*w[1] + w[2]*w[2];
    if (l2 == 0) return o;
    s = isqrt(l2 << 30);
    for (int i = 0; i < 3; i++) begin
      q = (mag(w[i]) << 30) / s;
      if (q > 32767) q = 32767;
      v[i] = w[i] < 0 ? -longint'(q) : longint'(q);
    end
    b = v[0]*c[0] + v[1]*c[1] + v[2]*c[2];
    rq = longint'(radius) << 15;
    h2 = 0;
    for (int i = 0; i < 3; i++) begin
      p = c[i] * 32768 - (b * v[i]) / 32768;
      ap = mag(p);
      if (ap > rq) return o;
      h2 += ap * ap;
    end
    if (h2 > rq * rq) return o;
    dq = isqrt(rq * rq - h2);
    t = b - longint'(dq);
    if (t <= 0) return o;
    ub = longint'(t) >> 15;
    if (ub > 65535) ub = 65535;
    o.hit = 1'b1;
    o.distance = ub[15:0];
    o.red = lit(color[23:16]);
    o.green = lit(color[15:8]);
    o.blue = lit(color[7:0]);
    return o;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // scoreboard on the result channel
  always @(posedge clk) begin
    shade_t e;
    if (rst_n && out_px.valid && out_px.ready) begin
      if (expected_px.size() == 0) begin
        report("unexpected beat", 1, 0);
      end else begin
        e = expected_px.pop_front();
        if (out_px.hit !== e.hit) report("hit", out_px.hit, e.hit);
        if (out_px.distance !== e.distance) report("distance", out_px.distance, e.distance);
        if (out_px.red !== e.red) report("red", out_px.red, e.red);
        if (out_px.green !== e.green) report("green", out_px.green, e.green);
        if (out_px.blue !== e.blue) report("blue", out_px.blue, e.blue);
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    int phase;
    phase = $urandom_range(0, 15);
    if (!rx_stall_en) out_px.ready <= 1'b1;
    else out_px.ready <= (phase < 11) || ($time / 20000) % 3 == 0;
  end

  task automatic reg_write(logic [rsps_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      rsps_pkg::REG_CENTER_X:        cx = val[15:0];
      rsps_pkg::REG_CENTER_Y:        cy = val[15:0];
      rsps_pkg::REG_CENTER_Z:        cz = val[15:0];
      rsps_pkg::REG_SPHERE_RADIUS:   radius = val[14:0];
      rsps_pkg::REG_SCREEN_DISTANCE: scr_dist = val[14:0];
      rsps_pkg::REG_LIGHT_LEVEL:     light = val[8:0];
      rsps_pkg::REG_SPHERE_COLOR:    color = val[23:0];
      default: ;
    endcase
  endtask

  task automatic load_scene(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] r,
                            logic [31:0] d, logic [31:0] l, logic [31:0] col);
    reg_write(rsps_pkg::REG_CENTER_X, x);
    reg_write(rsps_pkg::REG_CENTER_Y, y);
    reg_write(rsps_pkg::REG_CENTER_Z, z);
    reg_write(rsps_pkg::REG_SPHERE_RADIUS, r);
    reg_write(rsps_pkg::REG_SCREEN_DISTANCE, d);
    reg_write(rsps_pkg::REG_LIGHT_LEVEL, l);
    reg_write(rsps_pkg::REG_SPHERE_COLOR, col);
  endtask

  task automatic drain();
    while (expected_px.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic send_pixel(logic signed [11:0] px, logic signed [11:0] py, bit known,
                            shade_t res);
    shade_t p;
    in_pix.valid <= 1'b1;
    in_pix.pixel_x <= px;
    in_pix.pixel_y <= py;
    do @(posedge clk); while (!in_pix.ready);
    p = shade_pixel(px, py);
    if (known && p != res) report("table row vs predictor", p.distance, res.distance);
    expected_px.push_back(known ? res : p);
  endtask

  task automatic idle(int n);
    if (n > 0) begin
      in_pix.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic random_run(int n, int span);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n > 0; k++, n--)
        send_pixel($urandom_range(0, 1) ? 12'($urandom)
                                        : 12'($signed($urandom_range(0, 2*span)) - span),
                   $urandom_range(0, 1) ? 12'($urandom)
                                        : 12'($signed($urandom_range(0, 2*span)) - span),
                   1'b0, '{default: '0});
      if ($urandom_range(0, 3) != 0) idle($urandom_range(0, 6));
    end
    idle(1);
  endtask

  row_t dir_rows[] = '{
    '{12'sd0,     12'sd0,     1'b0, '{default: '0}},
    '{12'sd2047,  12'sd2047,  1'b1, '{1'b0, 16'd0, 8'd0, 8'd0, 8'd0}},
    '{-12'sd2048, -12'sd2048, 1'b1, '{1'b0, 16'd0, 8'd0, 8'd0, 8'd0}},
    '{12'sd2047,  -12'sd2048, 1'b1, '{1'b0, 16'd0, 8'd0, 8'd0, 8'd0}},
    '{12'sd100,   12'sd0,     1'b0, '{default: '0}},
    '{12'sd0,     -12'sd100,  1'b0, '{default: '0}},
    '{12'sd99,    12'sd99,    1'b0, '{default: '0}},
    '{12'sd101,   12'sd0,     1'b0, '{default: '0}},
    '{-12'sd50,   12'sd60,    1'b0, '{default: '0}},
    '{12'sd1,     -12'sd1,    1'b0, '{default: '0}}
  };

  initial begin
    cx = 0; cy = 0; cz = -16'sd1500; radius = 150; scr_dist = 1000;
    light = 135; color = 24'h33E6E6;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_pixel(dir_rows[i].x, dir_rows[i].y, dir_rows[i].known, dir_rows[i].res);
    idle(1);
    drain();

    // degenerate ray, zero radius, full light
    load_scene(0, 0, 32'hFFFF_F000, 0, 0, 511, 24'hFFFFFF);
    for (int i = 0; i < 4; i++) send_pixel(12'(i), 12'(-i), 1'b0, '{default: '0});
    idle(1);
    drain();

    // tangent and behind-eye cases
    load_scene(100, 0, 32'hFFFF_FC18, 100, 1000, 256, 24'h123456);
    send_pixel(0, 0, 1'b0, '{default: '0});
    send_pixel(100, 0, 1'b0, '{default: '0});
    send_pixel(200, 0, 1'b0, '{default: '0});
    idle(1);
    drain();
    load_scene(0, 0, 2000, 500, 1000, 0, 24'hFF00FF);
    send_pixel(0, 0, 1'b0, '{default: '0});
    send_pixel(12'sd2047, 12'sd2047, 1'b0, '{default: '0});
    idle(1);
    drain();

    // extreme center, large sphere, saturated distance region
    load_scene(32'h7FFF, 32'h8000, 32'h8000, 32'h7FFF, 32'h7FFF, 511, 24'h80FF01);
    send_pixel(12'sd2047, -12'sd2048, 1'b0, '{default: '0});
    send_pixel(0, 0, 1'b0, '{default: '0});
    idle(1);
    drain();

    load_scene(0, 0, 32'hFFFF_FA24, 150, 1000, 135, 24'h33E6E6);
    random_run(600, 120);
    drain();

    rx_stall_en = 1'b0;
    load_scene(32'h0000_0200, 32'hFFFF_FF00, 32'hFFFF_F800, 900, 800, 300, 24'hA5C3E7);
    random_run(600, 700);
    drain();

    rx_stall_en = 1'b1;
    for (int j = 0; j < 3; j++) begin
      load_scene($urandom_range(0, 65535) >> j*4, $urandom, $urandom | 32'h8000,
                 $urandom_range(1, 4000), $urandom_range(1, 32767), $urandom, $urandom);
      random_run(250, 400);
      drain();
    end

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
